@@ hw/rtl/rkfs_pkg.sv @@
// rkfs_pkg: shared types and constants of the rgb keyframe fade sequencer
// item structs, register indexes, opcode and mode codes, sequencer states
// no dependencies
`timescale 1ns / 1ps

package rkfs_pkg;

    // fixed field widths
    localparam int CHAN_W        = 8;
    localparam int COLOR_W       = 3 * CHAN_W;
    localparam int MODE_W        = 2;
    localparam int FRAME_COUNT_W = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_STEP      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS_DIV  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT     = 2'd3;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 5'd16;

    // opcodes of an input item
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // keyframe modes
    localparam logic [MODE_W-1:0] KEY_END  = 2'd0;
    localparam logic [MODE_W-1:0] KEY_FADE = 2'd2;

    // output modes
    localparam logic [1:0] OUT_OFF    = 2'd0;
    localparam logic [1:0] OUT_FROZEN = 2'd2;

    typedef struct packed {
        logic                opcode;
        logic [3:0]          entry_index;
        logic [CHAN_W-1:0]   entry_red;
        logic [CHAN_W-1:0]   entry_green;
        logic [CHAN_W-1:0]   entry_blue;
        logic [15:0]         entry_duration;
        logic [MODE_W-1:0]   entry_mode;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] pwm_red;
        logic [CHAN_W-1:0] pwm_green;
        logic [CHAN_W-1:0] pwm_blue;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_CAP_CUR,
        ST_RD_NXT,
        ST_CAP_NXT,
        ST_CHECK,
        ST_RD_ZERO,
        ST_CAP_ZERO,
        ST_CHAN,
        ST_MUL,
        ST_DIV,
        ST_BLOAD,
        ST_BDIV,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/rgb_keyframe_fade_sequencer_top.sv @@
// rgb_keyframe_fade_sequencer_top: keyframe table, frame sequencer, bit-serial
// fade interpolation and brightness division
// depends on rkfs_pkg
`timescale 1ns / 1ps

// Plays a table of TABLE_DEPTH RGB keyframes. A write item (opcode 1) loads one
// table entry and gives no result. A tick item (opcode 0) gives one PWM colour
// unless output_mode is 2 (frozen, no result, no state change); output_mode 0
// resets the sequence and loads its zero result through the done state. In play
// a tick reads the current and the next entry, rereads both when the frame
// advances and reads the first entry when the fade target wraps to it. The
// table sits in a memory with one write port and one registered read port,
// each read taking a read state and a capture state (current, next, first);
// each faded channel goes through an 8-step shift-add multiplier and an 8-step
// restoring divider by the duration, one channel after another, and the three
// channels are then divided by brightness_divider+1 in three bit-serial lanes.
// The block is ready for the next item once the result is loaded into the
// output register. A finished result waits in the output register while the
// next item is taken. The table reads as zero after reset through per-entry
// valid bits; there is no clearing pass.
module rgb_keyframe_fade_sequencer_top #(
    parameter int TABLE_DEPTH   = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  rkfs_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output rkfs_pkg::out_item_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [rkfs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rkfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DUR_W  = DURATION_BITS;
    localparam int PW     = DUR_W + rkfs_pkg::CHAN_W;
    localparam int CMP_W  = (IDX_W + 1 > rkfs_pkg::FRAME_COUNT_W) ? IDX_W + 1
                                                                 : rkfs_pkg::FRAME_COUNT_W;
    localparam int CW     = rkfs_pkg::CHAN_W;
    localparam int COL_W  = rkfs_pkg::COLOR_W;
    localparam int MW     = rkfs_pkg::MODE_W;

    // control state
    rkfs_pkg::state_t                   state_reg, state_next;
    logic [IDX_W-1:0]                   cur_reg, cur_next;
    logic [DUR_W-1:0]                   elapsed_reg, elapsed_next;
    logic [1:0]                         output_mode_reg, output_mode_next;
    logic [CW-1:0]                      speed_reg, speed_next;
    logic [CW-1:0]                      bdiv_reg, bdiv_next;
    logic [rkfs_pkg::FRAME_COUNT_W-1:0] frame_count_reg, frame_count_next;
    logic [1:0]                         chan_cnt_reg, chan_cnt_next;
    logic [2:0]                         bit_cnt_reg, bit_cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic [TABLE_DEPTH-1:0]             valid_reg;

    // datapath registers
    logic [COL_W-1:0]   c1_reg, c1_next;
    logic [COL_W-1:0]   c2_reg, c2_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [MW-1:0]      mode_cur_reg, mode_cur_next;
    logic [MW-1:0]      mode_nxt_reg, mode_nxt_next;
    logic [COL_W-1:0]   rgb_reg, rgb_next;
    logic [CW-1:0]      mul_a_reg, mul_a_next;
    logic [CW-1:0]      mul_b_reg, mul_b_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [PW-1:0]      ds_reg, ds_next;
    logic [CW-1:0]      q_reg, q_next;
    logic [DUR_W-1:0]   diff_reg, diff_next;
    logic [CW-1:0]      lane_dvd_reg [3];
    logic [CW-1:0]      lane_dvd_next [3];
    logic [CW:0]        lane_rem_reg [3];
    logic [CW:0]        lane_rem_next [3];
    rkfs_pkg::out_item_t out_data_reg, out_data_next;

    // keyframe memory
    logic [COL_W-1:0]   color_mem [TABLE_DEPTH];
    logic [DUR_W-1:0]   dur_mem   [TABLE_DEPTH];
    logic [MW-1:0]      mode_mem  [TABLE_DEPTH];
    logic [COL_W-1:0]   rd_color_reg;
    logic [DUR_W-1:0]   rd_dur_reg;
    logic [MW-1:0]      rd_mode_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;

    // helper signals
    logic               in_xfer;
    logic [IDX_W:0]     nxt_wide;
    logic               nxt_oob;
    logic [IDX_W-1:0]   adv_cur;
    logic               fade;
    logic [COL_W-1:0]   rd_color_eff;
    logic [DUR_W-1:0]   rd_dur_eff;
    logic [MW-1:0]      rd_mode_eff;
    logic [DUR_W:0]     elapsed_sum;
    logic               div_ge;
    logic [CW-1:0]      q_shift;
    logic [CW:0]        bdivisor;
    logic [CW:0]        lane_shift [3];
    logic               lane_ge [3];

    assign in_ready  = (state_reg == rkfs_pkg::ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // table write from a write item, ignored past the table end
    assign wr_addr = IDX_W'(in_data.entry_index);
    assign mem_we  = in_xfer && (in_data.opcode == rkfs_pkg::OP_WRITE)
                     && (CMP_W'(in_data.entry_index) < CMP_W'(TABLE_DEPTH));

    // entries never written read as zero
    assign rd_color_eff = rd_valid_reg ? rd_color_reg : '0;
    assign rd_dur_eff   = rd_valid_reg ? rd_dur_reg   : '0;
    assign rd_mode_eff  = rd_valid_reg ? rd_mode_reg  : rkfs_pkg::KEY_END;

    // next frame index and the advance rule
    assign nxt_wide = (IDX_W+1)'(cur_reg) + (IDX_W+1)'(1);
    assign nxt_oob  = nxt_wide >= (IDX_W+1)'(TABLE_DEPTH);
    always_comb
    begin
        if (mode_nxt_reg == rkfs_pkg::KEY_END)
        begin
            adv_cur = '0;
        end
        else if (CMP_W'(nxt_wide) >= CMP_W'(frame_count_reg))
        begin
            adv_cur = '0;
        end
        else
        begin
            adv_cur = nxt_wide[IDX_W-1:0];
        end
    end

    assign fade = (mode_cur_reg == rkfs_pkg::KEY_FADE) && (dur_reg != '0)
                  && (elapsed_reg <= dur_reg);

    // saturating counter step
    assign elapsed_sum = (DUR_W+1)'(elapsed_reg) + (DUR_W+1)'(speed_reg) + (DUR_W+1)'(1);

    // duration divider step
    assign div_ge  = acc_reg >= ds_reg;
    assign q_shift = {q_reg[CW-2:0], div_ge};

    // brightness divider lanes
    assign bdivisor = (CW+1)'(bdiv_reg) + (CW+1)'(1);
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_shift[k] = {lane_rem_reg[k][CW-1:0], lane_dvd_reg[k][CW-1]};
            lane_ge[k]    = lane_shift[k] >= bdivisor;
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        elapsed_next     = elapsed_reg;
        output_mode_next = output_mode_reg;
        speed_next       = speed_reg;
        bdiv_next        = bdiv_reg;
        frame_count_next = frame_count_reg;
        chan_cnt_next    = chan_cnt_reg;
        bit_cnt_next     = bit_cnt_reg;
        out_valid_next   = out_valid_reg;
        c1_next          = c1_reg;
        c2_next          = c2_reg;
        dur_next         = dur_reg;
        mode_cur_next    = mode_cur_reg;
        mode_nxt_next    = mode_nxt_reg;
        rgb_next         = rgb_reg;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        acc_next         = acc_reg;
        ds_next          = ds_reg;
        q_next           = q_reg;
        diff_next        = diff_reg;
        out_data_next    = out_data_reg;
        rd_addr          = cur_reg;
        for (int k = 0; k < 3; k++)
        begin
            lane_dvd_next[k] = lane_dvd_reg[k];
            lane_rem_next[k] = lane_rem_reg[k];
        end

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                rkfs_pkg::CFG_OUTPUT_MODE:    output_mode_next = cfg_data[1:0];
                rkfs_pkg::CFG_SPEED_STEP:     speed_next       = cfg_data;
                rkfs_pkg::CFG_BRIGHTNESS_DIV: bdiv_next        = cfg_data;
                rkfs_pkg::CFG_FRAME_COUNT:
                    frame_count_next = cfg_data[rkfs_pkg::FRAME_COUNT_W-1:0];
            endcase
        end

        // output transfer frees the result register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rkfs_pkg::ST_IDLE:
            begin
                chan_cnt_next = '0;
                if (in_xfer && (in_data.opcode == rkfs_pkg::OP_TICK))
                begin
                    priority if (output_mode_reg == rkfs_pkg::OUT_FROZEN)
                    begin
                        state_next = rkfs_pkg::ST_IDLE;
                    end
                    else if (output_mode_reg == rkfs_pkg::OUT_OFF)
                    begin
                        cur_next     = '0;
                        elapsed_next = '0;
                        rgb_next     = '0;
                        state_next   = rkfs_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rkfs_pkg::ST_RD_CUR;
                    end
                end
            end
            rkfs_pkg::ST_RD_CUR:
            begin
                rd_addr    = cur_reg;
                state_next = rkfs_pkg::ST_CAP_CUR;
            end
            rkfs_pkg::ST_CAP_CUR:
            begin
                c1_next       = rd_color_eff;
                dur_next      = rd_dur_eff;
                mode_cur_next = rd_mode_eff;
                state_next    = rkfs_pkg::ST_RD_NXT;
            end
            rkfs_pkg::ST_RD_NXT:
            begin
                rd_addr    = nxt_wide[IDX_W-1:0];
                state_next = rkfs_pkg::ST_CAP_NXT;
            end
            rkfs_pkg::ST_CAP_NXT:
            begin
                // past the table end counts as an end marker
                mode_nxt_next = nxt_oob ? rkfs_pkg::KEY_END : rd_mode_eff;
                c2_next       = rd_color_eff;
                state_next    = rkfs_pkg::ST_CHECK;
            end
            rkfs_pkg::ST_CHECK:
            begin
                priority if (elapsed_reg > dur_reg)
                begin
                    elapsed_next = '0;
                    cur_next     = adv_cur;
                    state_next   = rkfs_pkg::ST_RD_CUR;
                end
                else if (mode_nxt_reg == rkfs_pkg::KEY_END)
                begin
                    state_next = rkfs_pkg::ST_RD_ZERO;
                end
                else
                begin
                    state_next = rkfs_pkg::ST_CHAN;
                end
            end
            rkfs_pkg::ST_RD_ZERO:
            begin
                rd_addr    = '0;
                state_next = rkfs_pkg::ST_CAP_ZERO;
            end
            rkfs_pkg::ST_CAP_ZERO:
            begin
                // fade target wraps to the first entry
                c2_next    = rd_color_eff;
                state_next = rkfs_pkg::ST_CHAN;
            end
            rkfs_pkg::ST_CHAN:
            begin
                if (fade)
                begin
                    mul_a_next   = c1_reg[COL_W-1 -: CW];
                    mul_b_next   = c2_reg[COL_W-1 -: CW];
                    acc_next     = '0;
                    bit_cnt_next = '0;
                    diff_next    = dur_reg - elapsed_reg;
                    state_next   = rkfs_pkg::ST_MUL;
                end
                else
                begin
                    rgb_next = {rgb_reg[COL_W-CW-1:0], c1_reg[COL_W-1 -: CW]};
                    c1_next  = c1_reg << CW;
                    c2_next  = c2_reg << CW;
                    if (chan_cnt_reg == 2'd2)
                    begin
                        state_next = rkfs_pkg::ST_BLOAD;
                    end
                    else
                    begin
                        chan_cnt_next = chan_cnt_reg + 2'd1;
                    end
                end
            end
            rkfs_pkg::ST_MUL:
            begin
                // msb-first shift-add of e*b + (dur-e)*a
                acc_next = (acc_reg << 1)
                         + (mul_b_reg[CW-1] ? PW'(elapsed_reg) : PW'(0))
                         + (mul_a_reg[CW-1] ? PW'(diff_reg) : PW'(0));
                mul_a_next   = mul_a_reg << 1;
                mul_b_next   = mul_b_reg << 1;
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    ds_next      = PW'(dur_reg) << (CW - 1);
                    q_next       = '0;
                    bit_cnt_next = '0;
                    state_next   = rkfs_pkg::ST_DIV;
                end
            end
            rkfs_pkg::ST_DIV:
            begin
                // restoring division, quotient known to fit one channel
                if (div_ge)
                begin
                    acc_next = acc_reg - ds_reg;
                end
                q_next       = q_shift;
                ds_next      = ds_reg >> 1;
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    rgb_next = {rgb_reg[COL_W-CW-1:0], q_shift};
                    c1_next  = c1_reg << CW;
                    c2_next  = c2_reg << CW;
                    if (chan_cnt_reg == 2'd2)
                    begin
                        state_next = rkfs_pkg::ST_BLOAD;
                    end
                    else
                    begin
                        chan_cnt_next = chan_cnt_reg + 2'd1;
                        state_next    = rkfs_pkg::ST_CHAN;
                    end
                end
            end
            rkfs_pkg::ST_BLOAD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lane_dvd_next[k] = rgb_reg[(2-k)*CW +: CW];
                    lane_rem_next[k] = '0;
                end
                bit_cnt_next = '0;
                state_next   = rkfs_pkg::ST_BDIV;
            end
            rkfs_pkg::ST_BDIV:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lane_rem_next[k] = lane_ge[k] ? (lane_shift[k] - bdivisor) : lane_shift[k];
                    lane_dvd_next[k] = {lane_dvd_reg[k][CW-2:0], lane_ge[k]};
                end
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rgb_next[(2-k)*CW +: CW] = {lane_dvd_reg[k][CW-2:0], lane_ge[k]};
                    end
                    elapsed_next = elapsed_sum[DUR_W] ? {DUR_W{1'b1}} : elapsed_sum[DUR_W-1:0];
                    state_next   = rkfs_pkg::ST_DONE;
                end
            end
            rkfs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.pwm_red   = rgb_reg[3*CW-1 -: CW];
                    out_data_next.pwm_green = rgb_reg[2*CW-1 -: CW];
                    out_data_next.pwm_blue  = rgb_reg[CW-1:0];
                    out_valid_next          = 1'b1;
                    state_next              = rkfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rkfs_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rkfs_pkg::ST_IDLE;
            cur_reg         <= '0;
            elapsed_reg     <= '0;
            output_mode_reg <= rkfs_pkg::OUT_OFF;
            speed_reg       <= '0;
            bdiv_reg        <= '0;
            frame_count_reg <= rkfs_pkg::FRAME_COUNT_RESET;
            chan_cnt_reg    <= '0;
            bit_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            valid_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            elapsed_reg     <= elapsed_next;
            output_mode_reg <= output_mode_next;
            speed_reg       <= speed_next;
            bdiv_reg        <= bdiv_next;
            frame_count_reg <= frame_count_next;
            chan_cnt_reg    <= chan_cnt_next;
            bit_cnt_reg     <= bit_cnt_next;
            out_valid_reg   <= out_valid_next;
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        c1_reg       <= c1_next;
        c2_reg       <= c2_next;
        dur_reg      <= dur_next;
        mode_cur_reg <= mode_cur_next;
        mode_nxt_reg <= mode_nxt_next;
        rgb_reg      <= rgb_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        ds_reg       <= ds_next;
        q_reg        <= q_next;
        diff_reg     <= diff_next;
        out_data_reg <= out_data_next;
        for (int k = 0; k < 3; k++)
        begin
            lane_dvd_reg[k] <= lane_dvd_next[k];
            lane_rem_reg[k] <= lane_rem_next[k];
        end
    end

    // keyframe memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[wr_addr] <= {in_data.entry_red, in_data.entry_green, in_data.entry_blue};
            dur_mem[wr_addr]   <= DUR_W'(in_data.entry_duration);
            mode_mem[wr_addr]  <= in_data.entry_mode;
        end
        rd_color_reg <= color_mem[rd_addr];
        rd_dur_reg   <= dur_mem[rd_addr];
        rd_mode_reg  <= mode_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

`ifndef ASSERT_OFF
    // a frozen tick never produces a transfer on the result side
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_data.opcode == rkfs_pkg::OP_TICK)
         && (output_mode_reg == rkfs_pkg::OUT_FROZEN) && !out_valid_reg) |=> !out_valid_reg)
        else $error("frozen tick produced a result");

    // a table write completes in the cycle it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_data.opcode == rkfs_pkg::OP_WRITE)) |=> (state_reg == rkfs_pkg::ST_IDLE))
        else $error("write item left the sequencer busy");

    // frame index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        ((IDX_W+1)'(cur_reg) < (IDX_W+1)'(TABLE_DEPTH)))
        else $error("frame index beyond table depth");

    // duration divider remainder keeps the quotient within one channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkfs_pkg::ST_DIV) |-> (acc_reg < (ds_reg << 1)))
        else $error("fade quotient overflow");
`endif

endmodule

@@ verif/tb_rgb_keyframe_fade_sequencer_top.sv @@
// tb_rgb_keyframe_fade_sequencer_top: self-checking testbench for the keyframe fade sequencer
// predicts every pwm result from its own copy of the table and registers; random pacing
// depends on rkfs_pkg and rgb_keyframe_fade_sequencer_top
`timescale 1ns / 1ps

module tb_rgb_keyframe_fade_sequencer_top;

    localparam int          TABLE_DEPTH   = 16;
    localparam int unsigned DUR_MAX       = 32'hFFFF;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          RANDOM_ITEMS  = 480;
    localparam int          SAT_TICKS     = 262;

    // codes the package leaves unnamed
    localparam logic [1:0]                  OUT_PLAY     = 2'd1;
    localparam logic [1:0]                  OUT_PLAY_ALT = 2'd3;
    localparam logic [rkfs_pkg::MODE_W-1:0] KEY_HOLD     = 2'd1;
    localparam logic [rkfs_pkg::MODE_W-1:0] KEY_HOLD_ALT = 2'd3;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    rkfs_pkg::in_item_t               in_data;
    logic                             out_valid;
    logic                             out_ready;
    rkfs_pkg::out_item_t              out_data;
    logic                             cfg_write;
    logic [rkfs_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rkfs_pkg::CFG_DATA_W-1:0]  cfg_data;

    // register copies used by the predictor
    logic [1:0]  reg_out_mode;
    int unsigned reg_speed;
    int unsigned reg_div;
    int unsigned reg_count;

    // sequencer state copies
    int unsigned                 play_frame;
    int unsigned                 play_elapsed;
    logic [23:0]                 key_colour [TABLE_DEPTH];
    logic [15:0]                 key_dur    [TABLE_DEPTH];
    logic [rkfs_pkg::MODE_W-1:0] key_mode   [TABLE_DEPTH];

    rkfs_pkg::out_item_t pwm_expected [$];
    int unsigned fail_count;
    int unsigned ticks_sent;
    int unsigned writes_sent;
    int unsigned results_seen;
    int unsigned reg_updates;
    int unsigned src_calm;
    int unsigned sink_calm;

    rgb_keyframe_fade_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin : run_limit
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // idle length: mostly short, a few long, with calm stretches of none
    function automatic int unsigned gap_len(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic void clear_sequencer_model();
        reg_out_mode = rkfs_pkg::OUT_OFF;
        reg_speed    = 0;
        reg_div      = 0;
        reg_count    = rkfs_pkg::FRAME_COUNT_RESET;
        play_frame   = 0;
        play_elapsed = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            key_colour[i] = '0;
            key_dur[i]    = '0;
            key_mode[i]   = rkfs_pkg::KEY_END;
        end
    endfunction

    // an entry past the table end counts as an end marker
    function automatic bit ends_at(input int unsigned idx);
        if (idx >= TABLE_DEPTH)
            return 1'b1;
        return key_mode[idx] == rkfs_pkg::KEY_END;
    endfunction

    function automatic void play_refresh_tick();
        int unsigned cur;
        int unsigned a;
        int unsigned b;
        int unsigned dur;
        int unsigned e;
        int unsigned sh;
        int unsigned step;
        int unsigned lvl [3];
        logic [23:0] c1;
        logic [23:0] c2;
        rkfs_pkg::out_item_t pwm;
        if (reg_out_mode == rkfs_pkg::OUT_FROZEN)
            return;
        if (reg_out_mode == rkfs_pkg::OUT_OFF)
        begin
            play_frame   = 0;
            play_elapsed = 0;
            pwm_expected.push_back('0);
            return;
        end
        // frame advance once the counter passes the duration
        cur = play_frame;
        if (play_elapsed > key_dur[cur])
        begin
            play_elapsed = 0;
            if (ends_at(cur + 1))
                cur = 0;
            else
                cur = cur + 1;
            if (cur >= reg_count || cur >= TABLE_DEPTH)
                cur = 0;
        end
        play_frame = cur;
        // colour, faded towards the next entry or entry 0
        c1  = key_colour[cur];
        c2  = ends_at(cur + 1) ? key_colour[0] : key_colour[cur + 1];
        dur = key_dur[cur];
        e   = play_elapsed;
        for (int k = 0; k < 3; k++)
        begin
            sh = 16 - 8 * k;
            a  = (c1 >> sh) & 32'hFF;
            if (key_mode[cur] == rkfs_pkg::KEY_FADE && dur != 0 && e <= dur)
            begin
                b      = (c2 >> sh) & 32'hFF;
                lvl[k] = ((e * b + (dur - e) * a) / dur) & 32'hFF;
            end
            else
                lvl[k] = a;
        end
        // saturating counter step
        step = reg_speed + 1;
        if (play_elapsed > DUR_MAX - step)
            play_elapsed = DUR_MAX;
        else
            play_elapsed = play_elapsed + step;
        pwm.pwm_red   = 8'(lvl[0] / (reg_div + 1));
        pwm.pwm_green = 8'(lvl[1] / (reg_div + 1));
        pwm.pwm_blue  = 8'(lvl[2] / (reg_div + 1));
        pwm_expected.push_back(pwm);
    endfunction

    function automatic void absorb_transfer(input rkfs_pkg::in_item_t item);
        if (item.opcode == rkfs_pkg::OP_WRITE)
        begin
            key_colour[item.entry_index] = {item.entry_red, item.entry_green, item.entry_blue};
            key_dur[item.entry_index]    = item.entry_duration;
            key_mode[item.entry_index]   = item.entry_mode;
            writes_sent++;
        end
        else
        begin
            play_refresh_tick();
            ticks_sent++;
        end
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic rkfs_pkg::in_item_t keyframe_item(input int unsigned idx,
                                                         input logic [7:0] red,
                                                         input logic [7:0] green,
                                                         input logic [7:0] blue,
                                                         input logic [15:0] dur,
                                                         input logic [rkfs_pkg::MODE_W-1:0] mode);
        rkfs_pkg::in_item_t item;
        item.opcode         = rkfs_pkg::OP_WRITE;
        item.entry_index    = 4'(idx);
        item.entry_red      = red;
        item.entry_green    = green;
        item.entry_blue     = blue;
        item.entry_duration = dur;
        item.entry_mode     = mode;
        return item;
    endfunction

    function automatic rkfs_pkg::in_item_t random_keyframe(input int unsigned idx,
                                                           input logic [15:0] dur,
                                                           input logic [rkfs_pkg::MODE_W-1:0] mode);
        return keyframe_item(idx, 8'($urandom), 8'($urandom), 8'($urandom), dur, mode);
    endfunction

    // tick payload carries random junk beyond the opcode
    function automatic rkfs_pkg::in_item_t tick_item();
        rkfs_pkg::in_item_t item;
        item        = rkfs_pkg::in_item_t'({$urandom, $urandom});
        item.opcode = rkfs_pkg::OP_TICK;
        return item;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input rkfs_pkg::in_item_t item);
        int unsigned gap;
        gap = gap_len(src_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_transfer(item);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(tick_item());
    endtask

    // let every expected result arrive and the block go quiet
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pwm_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers from the predictor copies, back to back
    task automatic program_regs();
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= rkfs_pkg::CFG_OUTPUT_MODE;
        cfg_data  <= rkfs_pkg::CFG_DATA_W'(reg_out_mode);
        @(posedge clk);
        cfg_index <= rkfs_pkg::CFG_SPEED_STEP;
        cfg_data  <= rkfs_pkg::CFG_DATA_W'(reg_speed);
        @(posedge clk);
        cfg_index <= rkfs_pkg::CFG_BRIGHTNESS_DIV;
        cfg_data  <= rkfs_pkg::CFG_DATA_W'(reg_div);
        @(posedge clk);
        cfg_index <= rkfs_pkg::CFG_FRAME_COUNT;
        cfg_data  <= rkfs_pkg::CFG_DATA_W'(reg_count);
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_updates++;
    endtask

    // result sink pacing
    initial
    begin : sink_pacing
        int unsigned hold;
        int unsigned busy;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (hold) @(posedge clk);
            busy = gap_len(sink_calm);
            if (busy != 0)
            begin
                out_ready <= 1'b0;
                repeat (busy) @(posedge clk);
            end
        end
    end

    // result checker: each transfer against the oldest expectation
    always @(posedge clk)
    begin : pwm_checker
        rkfs_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pwm_expected.size() == 0)
            begin
                $error("unexpected pwm transfer %h", out_data);
                fail_count++;
            end
            else
            begin
                want = pwm_expected.pop_front();
                if (out_data.pwm_red !== want.pwm_red)
                begin
                    $error("pwm_red: expected %0d, got %0d", want.pwm_red, out_data.pwm_red);
                    fail_count++;
                end
                if (out_data.pwm_green !== want.pwm_green)
                begin
                    $error("pwm_green: expected %0d, got %0d", want.pwm_green,
                           out_data.pwm_green);
                    fail_count++;
                end
                if (out_data.pwm_blue !== want.pwm_blue)
                begin
                    $error("pwm_blue: expected %0d, got %0d", want.pwm_blue, out_data.pwm_blue);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset values: output off, ticks answer zero
    task automatic test_off_mode();
        send_item(tick_item());
        send_item(keyframe_item(0, 8'hFF, 8'hFF, 8'hFF, 16'd3, KEY_HOLD));
        send_item(tick_item());
    endtask

    // hold, fade, zero-length fade, mode 3 as hold, end marker wrap
    task automatic test_sequence_modes();
        send_item(keyframe_item(0, 8'hFF, 8'h00, 8'h80, 16'd1, rkfs_pkg::KEY_FADE));
        send_item(keyframe_item(1, 8'h00, 8'hFF, 8'h01, 16'd0, rkfs_pkg::KEY_FADE));
        send_item(keyframe_item(2, 8'h12, 8'h34, 8'h56, 16'd2, KEY_HOLD_ALT));
        send_item(keyframe_item(3, 8'hAA, 8'h55, 8'hFF, 16'hFFFF, rkfs_pkg::KEY_END));
        reg_out_mode = OUT_PLAY;
        reg_speed    = 0;
        reg_div      = 0;
        reg_count    = TABLE_DEPTH;
        program_regs();
        send_ticks(8);
    endtask

    // frozen output, alternate play code, divider and frame count extremes
    task automatic test_register_extremes();
        reg_out_mode = rkfs_pkg::OUT_FROZEN;
        program_regs();
        send_ticks(2);
        reg_out_mode = OUT_PLAY_ALT;
        program_regs();
        send_ticks(1);
        reg_div   = 255;
        reg_count = 0;
        program_regs();
        send_ticks(2);
        reg_div   = 1;
        reg_count = 31;
        program_regs();
        send_ticks(1);
    endtask

    // long fade at top speed until the counter sticks at its maximum
    task automatic test_counter_saturation();
        reg_out_mode = rkfs_pkg::OUT_OFF;
        reg_speed    = 255;
        reg_div      = 0;
        reg_count    = TABLE_DEPTH;
        program_regs();
        send_item(random_keyframe(0, 16'hFFFF, rkfs_pkg::KEY_FADE));
        send_item(random_keyframe(1, 16'd5, KEY_HOLD));
        send_item(tick_item());
        reg_out_mode = OUT_PLAY;
        program_regs();
        send_ticks(SAT_TICKS);
    endtask

    // random register settings with random well-formed programs and some noise
    task automatic test_random_programs();
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        int unsigned n_ticks;
        logic [15:0] dur;
        logic [1:0]  play_code;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            play_code    = r[0] ? OUT_PLAY : OUT_PLAY_ALT;
            reg_out_mode = (r < 8) ? play_code
                         : (r == 8) ? rkfs_pkg::OUT_OFF : rkfs_pkg::OUT_FROZEN;
            r = $urandom_range(0, 99);
            reg_speed = (r < 15) ? 0 : (r < 30) ? 255 : (r < 80) ? $urandom_range(0, 7)
                                                                 : $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            reg_div = (r < 30) ? 0 : (r < 45) ? 255 : $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            reg_count = (r < 8) ? 0 : (r < 16) ? 1 : (r < 50) ? TABLE_DEPTH
                      : (r < 65) ? $urandom_range(17, 31) : $urandom_range(2, 15);
            program_regs();
            // keyframe program terminated by an end marker or by the table end
            len = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : $urandom_range(1, TABLE_DEPTH);
            for (int i = 0; i < len; i++)
            begin
                r   = $urandom_range(0, 99);
                dur = (r < 15) ? 16'd0 : (r < 90) ? 16'($urandom_range(1, 12))
                                                  : 16'($urandom);
                r   = $urandom_range(0, 9);
                send_item(random_keyframe(i, dur, (r < 4) ? KEY_HOLD
                                                  : (r < 9) ? rkfs_pkg::KEY_FADE : KEY_HOLD_ALT));
            end
            if (len < TABLE_DEPTH)
                send_item(random_keyframe(len, 16'($urandom), rkfs_pkg::KEY_END));
            sent += len + 1;
            n_ticks = $urandom_range(15, 40);
            for (int t = 0; t < n_ticks; t++)
            begin
                // noise: a stray write of any entry, any fields
                if ($urandom_range(0, 99) < 8)
                    send_item(random_keyframe($urandom_range(0, TABLE_DEPTH - 1),
                                              16'($urandom), 2'($urandom)));
                else
                    send_item(tick_item());
                sent++;
                // occasional freeze mid-sequence, then back to play
                if (t == n_ticks / 2 && $urandom_range(0, 3) == 0)
                begin
                    reg_out_mode = rkfs_pkg::OUT_FROZEN;
                    program_regs();
                    send_ticks(3);
                    reg_out_mode = play_code;
                    program_regs();
                    sent += 3;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin : main_sequence
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        fail_count   = 0;
        ticks_sent   = 0;
        writes_sent  = 0;
        results_seen = 0;
        reg_updates  = 0;
        src_calm     = 0;
        sink_calm    = 0;
        clear_sequencer_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_off_mode();
        test_sequence_modes();
        test_register_extremes();
        test_counter_saturation();
        test_random_programs();

        quiesce();
        $display("covered %0d ticks, %0d keyframe writes, %0d pwm results checked",
                 ticks_sent, writes_sent, results_seen);
        $display("over %0d register settings incl. frozen, off and counter saturation",
                 reg_updates);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rkfs_pkg.sv
hw/rtl/rgb_keyframe_fade_sequencer_top.sv
verif/tb_rgb_keyframe_fade_sequencer_top.sv
